[src/dns_a_record_reply_parser_assert.svh]
// Assertion macros for the DNS A-record reply parser checker.
// Standalone header; the only user is the checker file.
`ifndef DNS_A_RECORD_REPLY_PARSER_ASSERT_SVH
`define DNS_A_RECORD_REPLY_PARSER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DNSARP_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("dnsarp same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define DNSARP_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("dnsarp next-cycle check failed");

`endif

[src/dnsarp_pkg.sv]
// Shared types and constants of the DNS A-record reply parser.
// No dependencies; used by the top level and by its checker.
package dnsarp_pkg;

	localparam int MAX_REPLY  = 256;
	localparam int OFF_W      = $clog2(MAX_REPLY + 1);
	localparam int QE_W       = 9;
	localparam int CMP_W      = (OFF_W > QE_W) ? OFF_W : QE_W;
	localparam int HEADER_LEN = 12;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;
	localparam int OUT_W      = 40;

	localparam logic [15:0]     RST_EXPECTED_ID  = 16'hBEEF;
	localparam logic [QE_W-1:0] RST_QUESTION_END = 9'd29;
	localparam logic [7:0]      PTR_MASK         = 8'hC0;
	localparam logic [15:0]     TYPE_A           = 16'd1;
	localparam logic [15:0]     LEN_A            = 16'd4;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_EXPECTED_ID  = 1'b0,
		CFG_QUESTION_END = 1'b1
	} cfg_idx_t;

	typedef enum logic [2:0] {
		PH_HEADER,
		PH_GAP,
		PH_NAME,
		PH_PTR,
		PH_FIXED,
		PH_RDATA
	} phase_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_SHORT   = 3'd1,
		ST_ID      = 3'd2,
		ST_NOTRESP = 3'd3,
		ST_NOANS   = 3'd4,
		ST_TRUNC   = 3'd5,
		ST_NOA     = 3'd6
	} status_t;

endpackage

[src/dns_a_record_reply_parser.sv]
// The result appears on m_tvalid in the cycle after the request carrying the last byte.
// Throughput: one reply byte per cycle; each byte updates counters and compares only.
// The input stalls only while a finished result waits for m_tready.
// One result per reply, issued for the byte flagged by s_tlast.
// Reset (arst_n low, asynchronous): parse state cleared, no result pending,
// expected_id back to 0xBEEF and question_end back to 29.
module dns_a_record_reply_parser (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration write port
	input  logic                                cfg_we,
	input  logic [dnsarp_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [dnsarp_pkg::CFG_DATA_W-1:0]   cfg_data,
	// reply byte stream
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [7:0]                          s_tdata,   // [7:0] data_byte
	input  logic                                s_tlast,   // last byte of the reply
	// result stream
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [dnsarp_pkg::OUT_W-1:0]        m_tdata    // [0] found, [3:1] status,
	                                                       // [35:4] address, [39:36] zero
);

	// Configuration registers.
	logic [15:0]                 expected_id_q;
	logic [dnsarp_pkg::QE_W-1:0] question_end_q;
	logic [dnsarp_pkg::QE_W-1:0] qe_eff;

	// Parse state.
	logic [dnsarp_pkg::OFF_W-1:0] off_q, off_d, off_inc;
	dnsarp_pkg::phase_t           phase_q, phase_d;
	logic [15:0]                  rid_q, rid_d;
	logic                         resp_q, resp_d;
	logic [15:0]                  ans_q, ans_d;
	logic [15:0]                  rec_q, rec_d, rec_inc;
	logic [15:0]                  skip_q, skip_d;
	logic [3:0]                   fidx_q, fidx_d, fidx_inc;
	logic [15:0]                  rtype_q, rtype_d;
	logic [15:0]                  rlen_q, rlen_d;
	logic [31:0]                  addr_q, addr_d;
	logic                         vset_q, vset_d;    // verdict reached
	dnsarp_pkg::status_t          vcode_q, vcode_d;

	// Result register.
	logic                         out_valid_q;
	logic                         out_found_q;
	dnsarp_pkg::status_t          out_status_q;
	logic [31:0]                  out_addr_q;

	logic                         in_acc;
	logic                         in_range;
	logic                         res_found;
	dnsarp_pkg::status_t          res_status;

	assign s_tready = !out_valid_q || m_tready;
	assign in_acc   = s_tvalid && s_tready;
	assign in_range = off_q < dnsarp_pkg::OFF_W'(dnsarp_pkg::MAX_REPLY);
	assign off_inc  = off_q + 1'b1;
	assign rec_inc  = rec_q + 1'b1;
	assign fidx_inc = fidx_q + 1'b1;

	// Question end below the header length acts as the header length.
	assign qe_eff = (question_end_q < dnsarp_pkg::QE_W'(dnsarp_pkg::HEADER_LEN))
		? dnsarp_pkg::QE_W'(dnsarp_pkg::HEADER_LEN) : question_end_q;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'b0000, out_addr_q, out_status_q, out_found_q};

	// Configuration writes: take the register by index, no read-back.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_id_q  <= dnsarp_pkg::RST_EXPECTED_ID;
			question_end_q <= dnsarp_pkg::RST_QUESTION_END;
		end else if (cfg_we) begin
			unique case (cfg_index)
				dnsarp_pkg::CFG_EXPECTED_ID:  expected_id_q  <= cfg_data;
				dnsarp_pkg::CFG_QUESTION_END: question_end_q <= cfg_data[dnsarp_pkg::QE_W-1:0];
				default: ;
			endcase
		end
	end

	// Per-byte parse step and end-of-reply verdict.
	always_comb begin
		off_d   = off_q;
		phase_d = phase_q;
		rid_d   = rid_q;
		resp_d  = resp_q;
		ans_d   = ans_q;
		rec_d   = rec_q;
		skip_d  = skip_q;
		fidx_d  = fidx_q;
		rtype_d = rtype_q;
		rlen_d  = rlen_q;
		addr_d  = addr_q;
		vset_d  = vset_q;
		vcode_d = vcode_q;

		// Bytes past the maximum reply length are not parsed and not counted.
		if (in_acc && in_range) begin
			off_d = off_inc;
			if (!vset_q) begin
				unique case (phase_q)
					dnsarp_pkg::PH_HEADER, dnsarp_pkg::PH_GAP: begin
						if (off_q == dnsarp_pkg::OFF_W'(0)) begin
							rid_d = {s_tdata, 8'h00};
						end else if (off_q == dnsarp_pkg::OFF_W'(1)) begin
							rid_d = {rid_q[15:8], s_tdata};
						end else if (off_q == dnsarp_pkg::OFF_W'(2)) begin
							resp_d = s_tdata[7];
						end else if (off_q == dnsarp_pkg::OFF_W'(6)) begin
							ans_d = {s_tdata, 8'h00};
						end else if (off_q == dnsarp_pkg::OFF_W'(7)) begin
							ans_d = {ans_q[15:8], s_tdata};
							// Header checks in priority order: id, QR bit, answer count.
							if (rid_q != expected_id_q) begin
								vset_d  = 1'b1;
								vcode_d = dnsarp_pkg::ST_ID;
							end else if (!resp_q) begin
								vset_d  = 1'b1;
								vcode_d = dnsarp_pkg::ST_NOTRESP;
							end else if ({ans_q[15:8], s_tdata} == 16'd0) begin
								vset_d  = 1'b1;
								vcode_d = dnsarp_pkg::ST_NOANS;
							end
						end
						// Past the header, wait for the start of the answer section.
						if (off_inc >= dnsarp_pkg::OFF_W'(dnsarp_pkg::HEADER_LEN)) begin
							if (dnsarp_pkg::CMP_W'(off_inc) == dnsarp_pkg::CMP_W'(qe_eff)) begin
								phase_d = dnsarp_pkg::PH_NAME;
								fidx_d  = 4'd0;
								skip_d  = 16'd0;
							end else begin
								phase_d = dnsarp_pkg::PH_GAP;
							end
						end
					end
					dnsarp_pkg::PH_NAME: begin
						if (fidx_q == 4'd0) begin
							// Only the first byte of a name can mark a pointer.
							if ((s_tdata & dnsarp_pkg::PTR_MASK) == dnsarp_pkg::PTR_MASK) begin
								phase_d = dnsarp_pkg::PH_PTR;
							end else if (s_tdata == 8'h00) begin
								phase_d = dnsarp_pkg::PH_FIXED;
								fidx_d  = 4'd0;
							end else begin
								fidx_d = 4'd1;
								skip_d = {8'h00, s_tdata};
							end
						end else if (skip_q != 16'd0) begin
							skip_d = skip_q - 1'b1;
						end else if (s_tdata == 8'h00) begin
							phase_d = dnsarp_pkg::PH_FIXED;
							fidx_d  = 4'd0;
						end else begin
							skip_d = {8'h00, s_tdata};
						end
					end
					dnsarp_pkg::PH_PTR: begin
						phase_d = dnsarp_pkg::PH_FIXED;
						fidx_d  = 4'd0;
					end
					dnsarp_pkg::PH_FIXED: begin
						if (fidx_q == 4'd0) begin
							rtype_d = {s_tdata, 8'h00};
						end else if (fidx_q == 4'd1) begin
							rtype_d = {rtype_q[15:8], s_tdata};
						end else if (fidx_q == 4'd8) begin
							rlen_d = {s_tdata, 8'h00};
						end else if (fidx_q == 4'd9) begin
							rlen_d = {rlen_q[15:8], s_tdata};
						end
						fidx_d = fidx_inc;
						// Tenth fixed byte: rdlength is complete.
						if (fidx_q == 4'd9) begin
							fidx_d = 4'd0;
							addr_d = 32'd0;
							skip_d = rlen_d;
							if (rlen_d == 16'd0) begin
								rec_d = rec_inc;
								if (rec_inc == ans_q) begin
									vset_d  = 1'b1;
									vcode_d = dnsarp_pkg::ST_NOA;
								end else begin
									phase_d = dnsarp_pkg::PH_NAME;
									skip_d  = 16'd0;
								end
							end else begin
								phase_d = dnsarp_pkg::PH_RDATA;
							end
						end
					end
					dnsarp_pkg::PH_RDATA: begin
						if (rtype_q == dnsarp_pkg::TYPE_A && rlen_q == dnsarp_pkg::LEN_A) begin
							// Shift in the address, first byte most significant.
							addr_d = {addr_q[23:0], s_tdata};
							fidx_d = fidx_inc;
							if (fidx_inc >= 4'd4) begin
								vset_d  = 1'b1;
								vcode_d = dnsarp_pkg::ST_OK;
							end
						end else begin
							if (skip_q != 16'd0) begin
								skip_d = skip_q - 1'b1;
							end
							if (skip_d == 16'd0) begin
								rec_d = rec_inc;
								if (rec_inc == ans_q) begin
									vset_d  = 1'b1;
									vcode_d = dnsarp_pkg::ST_NOA;
								end else begin
									phase_d = dnsarp_pkg::PH_NAME;
									fidx_d  = 4'd0;
									skip_d  = 16'd0;
								end
							end
						end
					end
					default: ;
				endcase
			end
		end

		// Verdict for the reply: short beats everything, no verdict means cut short.
		if (off_d < dnsarp_pkg::OFF_W'(dnsarp_pkg::HEADER_LEN)) begin
			res_status = dnsarp_pkg::ST_SHORT;
		end else if (!vset_d) begin
			res_status = dnsarp_pkg::ST_TRUNC;
		end else begin
			res_status = vcode_d;
		end
		res_found = (res_status == dnsarp_pkg::ST_OK);

		// Last byte: drop the parse state so the next byte starts a new reply.
		if (in_acc && s_tlast) begin
			off_d   = '0;
			phase_d = dnsarp_pkg::PH_HEADER;
			rid_d   = 16'd0;
			resp_d  = 1'b0;
			ans_d   = 16'd0;
			rec_d   = 16'd0;
			skip_d  = 16'd0;
			fidx_d  = 4'd0;
			rtype_d = 16'd0;
			rlen_d  = 16'd0;
			vset_d  = 1'b0;
			vcode_d = dnsarp_pkg::ST_OK;
		end
	end

	// Parse state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q   <= '0;
			phase_q <= dnsarp_pkg::PH_HEADER;
			rid_q   <= 16'd0;
			resp_q  <= 1'b0;
			ans_q   <= 16'd0;
			rec_q   <= 16'd0;
			skip_q  <= 16'd0;
			fidx_q  <= 4'd0;
			rtype_q <= 16'd0;
			rlen_q  <= 16'd0;
			addr_q  <= 32'd0;
			vset_q  <= 1'b0;
			vcode_q <= dnsarp_pkg::ST_OK;
		end else begin
			off_q   <= off_d;
			phase_q <= phase_d;
			rid_q   <= rid_d;
			resp_q  <= resp_d;
			ans_q   <= ans_d;
			rec_q   <= rec_d;
			skip_q  <= skip_d;
			fidx_q  <= fidx_d;
			rtype_q <= rtype_d;
			rlen_q  <= rlen_d;
			addr_q  <= (in_acc && s_tlast) ? 32'd0 : addr_d;
			vset_q  <= vset_d;
			vcode_q <= vcode_d;
		end
	end

	// Result valid: set by the last byte, cleared when the result is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_acc && s_tlast) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload: load with the last byte, hold otherwise.
	always_ff @(posedge clk) begin
		if (in_acc && s_tlast) begin
			out_found_q  <= res_found;
			out_status_q <= res_status;
			out_addr_q   <= res_found ? addr_d : 32'd0;
		end
	end

endmodule

[src/dnsarp_checker.sv]
// Port-level checker for the DNS A-record reply parser, bound to its top level.
// Depends on dnsarp_pkg and dns_a_record_reply_parser_assert.svh.
`include "dns_a_record_reply_parser_assert.svh"

module dnsarp_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         s_tvalid,
	input logic                         s_tready,
	input logic                         s_tlast,
	input logic                         m_tvalid,
	input logic                         m_tready,
	input logic [dnsarp_pkg::OUT_W-1:0] m_tdata
);

	logic found_ok;
	logic stalled;

	assign found_ok = m_tdata[0] == (m_tdata[3:1] == dnsarp_pkg::ST_OK);
	assign stalled  = m_tvalid && !m_tready;

	`DNSARP_ASSERT_IMP(a_found_iff_ok, clk, arst_n, m_tvalid, found_ok)
	`DNSARP_ASSERT_IMP(a_no_addr_when_missing, clk, arst_n, m_tvalid && !m_tdata[0], m_tdata[35:4] == 32'd0)
	`DNSARP_ASSERT_NXT(a_last_gives_result, clk, arst_n, s_tvalid && s_tready && s_tlast, m_tvalid)
	`DNSARP_ASSERT_IMP(a_full_blocks_input, clk, arst_n, stalled, !s_tready)
	`DNSARP_ASSERT_NXT(a_stalled_result_holds, clk, arst_n, stalled, m_tvalid && $stable(m_tdata))

endmodule

bind dns_a_record_reply_parser dnsarp_checker u_dnsarp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tlast  (s_tlast),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
